// File: rtl/core/neighbor_table_oldest_evict_macros.svh
// Assertion macros used by the neighbor table sequencer RTL.
`ifndef NEIGHBOR_TABLE_OLDEST_EVICT_MACROS_SVH
`define NEIGHBOR_TABLE_OLDEST_EVICT_MACROS_SVH
`ifndef ASSERT_OFF
`define NT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define NT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/nto_pkg.sv
// Package with shared types and constants of the neighbor table.
package nto_pkg;
  localparam int unsigned DefEntries = 16;
  localparam int unsigned SaveEvery  = 5;
  localparam logic [15:0] CountMax   = 16'hFFFF;
  localparam logic [1:0]  KindClient   = 2'd0;
  localparam logic [1:0]  KindRepeater = 2'd1;
  localparam logic [1:0]  KindRoom     = 2'd2;
  localparam logic [1:0]  KindUnused   = 2'd3;
  localparam logic        FuncUpdate = 1'b0;
  localparam logic        FuncLookup = 1'b1;

  // One table entry.
  typedef struct packed {
    logic [7:0]  key;
    logic [31:0] seen_ms;
    logic [31:0] adv_time;
    logic [8:0]  rssi;
    logic [7:0]  snr;
    logic [7:0]  hops;
    logic [1:0]  kind;
  } entry_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic shift;   // rotate the ring by one cell
    logic write;   // cell 0 takes wr_entry
  } cell_ctl_t;
endpackage

// File: rtl/core/nto_cell.sv
// One storage cell of the rotating neighbor table ring.
module nto_cell (
  input  logic              clk,
  input  nto_pkg::cell_ctl_t ctl,
  input  logic              is_head,
  input  nto_pkg::entry_t   wr_entry,
  input  nto_pkg::entry_t   prev_entry,
  output nto_pkg::entry_t   entry
);
  import nto_pkg::*;
  entry_t entry_r, entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift) begin
      entry_nxt = prev_entry;
    end else if (ctl.write && is_head) begin
      entry_nxt = wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
endmodule

// File: rtl/core/nto_ctrl.sv
// Sequencer that scans the ring, updates the head cell and keeps the counters.
`include "neighbor_table_oldest_evict_macros.svh"
module nto_ctrl #(
  parameter int unsigned TABLE_ENTRIES = nto_pkg::DefEntries
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [99:0]         in_bits,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [71:0]         out_bits,
  input  nto_pkg::entry_t     head,
  output nto_pkg::cell_ctl_t  ctl,
  output nto_pkg::entry_t     wr_entry
);
  import nto_pkg::*;
  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned FW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SEEK  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [99:0] item_r, item_nxt;
  logic [IW-1:0] pos_r, pos_nxt;        // ring offset of the head cell
  logic [IW:0]   cnt_r, cnt_nxt;        // cells seen in this pass
  logic [IW-1:0] tgt_r, tgt_nxt;        // slot to write
  logic [IW-1:0] old_r, old_nxt;
  logic [31:0]   oldt_r, oldt_nxt;
  logic [1:0]    oldk_r, oldk_nxt;
  logic          hit_r, hit_nxt;
  logic [7:0]    hhops_r, hhops_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [15:0]   ctr_r [3], ctr_nxt [3];
  logic [2:0]    ins_r, ins_nxt;
  logic [71:0]   res_r, res_nxt;
  logic          ovld_r, ovld_nxt;
  logic          pass_done;

  logic        i_func;
  logic [7:0]  i_key, i_hops;
  logic [31:0] i_now, i_adv;
  logic [8:0]  i_rssi;
  logic [7:0]  i_snr;
  logic [1:0]  i_kind;
  assign i_func = item_r[0];
  assign i_key  = item_r[8:1];
  assign i_now  = item_r[40:9];
  assign i_adv  = item_r[72:41];
  assign i_rssi = item_r[81:73];
  assign i_snr  = item_r[89:82];
  assign i_hops = item_r[97:90];
  assign i_kind = item_r[99:98];

  assign pass_done = (cnt_r == (IW+1)'(TABLE_ENTRIES));

  always_comb begin
    logic [IW:0] used;
    logic        full, ins, sv;
    logic [7:0]  best;
    logic [FW-1:0] fl;
    logic [2:0]  ic;
    state_nxt = state_r;
    item_nxt = item_r; pos_nxt = pos_r; cnt_nxt = cnt_r; tgt_nxt = tgt_r;
    old_nxt = old_r; oldt_nxt = oldt_r; oldk_nxt = oldk_r; hit_nxt = hit_r;
    hhops_nxt = hhops_r; fill_nxt = fill_r; ctr_nxt = ctr_r; ins_nxt = ins_r;
    res_nxt = res_r; ovld_nxt = ovld_r;
    ctl = '0;
    wr_entry = head;
    used = (IW+1)'(fill_r);
    full = (used == (IW+1)'(TABLE_ENTRIES));
    ins = 1'b0; sv = 1'b0; best = 8'd0; fl = fill_r; ic = ins_r;
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && !ovld_r) begin
          item_nxt = in_bits; cnt_nxt = '0; hit_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Head cell holds slot pos_r; one cell per cycle passes by.
        if (pass_done) begin
          if (hit_r || i_func == FuncLookup) begin
            tgt_nxt = tgt_r;
          end else if (full) begin
            tgt_nxt = old_r;
          end else begin
            tgt_nxt = used[IW-1:0];
          end
          state_nxt = S_SEEK;
        end else begin
          if (!hit_r && {1'b0, pos_r} < used && head.key == i_key) begin
            hit_nxt = 1'b1; tgt_nxt = pos_r; hhops_nxt = head.hops;
          end
          // The pass may start mid-ring, so a tie goes to the lower slot.
          if (cnt_r == '0 || head.seen_ms < oldt_r ||
              (head.seen_ms == oldt_r && pos_r < old_r)) begin
            old_nxt = pos_r; oldt_nxt = head.seen_ms; oldk_nxt = head.kind;
          end
          ctl.shift = 1'b1;
          pos_nxt = (pos_r == IW'(TABLE_ENTRIES - 1)) ? '0 : pos_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SEEK: begin
        if (i_func == FuncLookup || pos_r == tgt_r) begin
          if (i_func == FuncLookup) begin
            best = hit_r ? hhops_r : 8'd0;
          end else begin
            ins = !hit_r;
            wr_entry.key = i_key; wr_entry.seen_ms = i_now;
            wr_entry.adv_time = i_adv; wr_entry.rssi = i_rssi;
            wr_entry.snr = i_snr; wr_entry.kind = i_kind;
            best = (hit_r && hhops_r <= i_hops) ? hhops_r : i_hops;
            wr_entry.hops = best;
            ctl.write = 1'b1;
            if (ins) begin
              if (full) begin
                if (oldk_r != KindUnused && ctr_r[oldk_r] != 16'd0)
                  ctr_nxt[oldk_r] = ctr_r[oldk_r] - 16'd1;
              end else begin
                fl = fill_r + 1'b1;
              end
              if (i_kind != KindUnused && ctr_nxt[i_kind] != CountMax)
                ctr_nxt[i_kind] = ctr_nxt[i_kind] + 16'd1;
              ic = ins_r + 3'd1;
              if (ic >= 3'(SaveEvery)) begin
                sv = 1'b1; ic = 3'd0;
              end
            end
          end
          fill_nxt = fl; ins_nxt = ic;
          res_nxt = {4'd0, sv, ctr_nxt[KindRoom], ctr_nxt[KindRepeater],
                     ctr_nxt[KindClient], 5'(fl), best,
                     ins && full, 4'(hit_r || ins ? tgt_r : '0), hit_r};
          state_nxt = S_OUT;
        end else begin
          ctl.shift = 1'b1;
          pos_nxt = (pos_r == IW'(TABLE_ENTRIES - 1)) ? '0 : pos_r + 1'b1;
        end
      end
      S_OUT: begin
        ovld_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; pos_r <= '0; cnt_r <= '0; hit_r <= 1'b0;
      fill_r <= '0; ins_r <= '0; ovld_r <= 1'b0;
      ctr_r[0] <= '0; ctr_r[1] <= '0; ctr_r[2] <= '0;
    end else begin
      state_r <= state_nxt; pos_r <= pos_nxt; cnt_r <= cnt_nxt; hit_r <= hit_nxt;
      fill_r <= fill_nxt; ins_r <= ins_nxt; ovld_r <= ovld_nxt; ctr_r <= ctr_nxt;
    end
    item_r <= item_nxt; tgt_r <= tgt_nxt; old_r <= old_nxt; oldt_r <= oldt_nxt;
    oldk_r <= oldk_nxt; hhops_r <= hhops_nxt; res_r <= res_nxt;
  end

  assign in_tready  = (state_r == S_IDLE) && !ovld_r;
  assign out_tvalid = ovld_r;
  assign out_bits   = res_r;

  `NT_ASSERT_IMP(a_fill_max, clk, rst_n, 1'b1, fill_r <= FW'(TABLE_ENTRIES))
  `NT_ASSERT_IMP(a_ins_max, clk, rst_n, 1'b1, ins_r < 3'(SaveEvery))
  `NT_ASSERT_NXT(a_take_scan, clk, rst_n, in_tvalid && in_tready, state_r == S_SCAN)
  `NT_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_tready)
endmodule

// File: rtl/core/neighbor_table_oldest_evict.sv
// Top level of the neighbor table with oldest-entry eviction.
//
//  Channel | Dir | Handshake            | Payload
//  in_     | in  | in_tvalid/in_tready   | in_tdata: func..node_kind
//  out_    | out | out_tvalid/out_tready | out_tdata: found..save_due
//
// The entries live in a ring of TABLE_ENTRIES cells that rotates one cell per
// cycle while an item is scanned or sought; the sequencer only sees the head
// cell. An item takes one full rotation to scan for the first match and the
// oldest entry; then, for an update, the ring shifts until the target slot is
// at the head and the entry is written there. The result is registered in
// S_SEEK and S_OUT then raises out_tvalid. A new input transfer is taken only
// in S_IDLE with the output register empty.
// Reset (rst_n low, synchronous) clears the fill level, counters and save
// count; entry contents are left as they are. A stalled result holds in the
// output register and blocks the next input transfer until it is taken.
module neighbor_table_oldest_evict #(
  parameter int unsigned TABLE_ENTRIES = nto_pkg::DefEntries
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func[0], key_hash[8:1], now_ms[40:9], advert_time[72:41], rssi[81:73],
  // snr[89:82], hop_count[97:90], node_kind[99:98], zero fill to 104.
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // found[0], slot[4:1], evicted[5], best_hops[13:6], used_entries[18:14],
  // clients_seen[34:19], repeaters_seen[50:35], rooms_seen[66:51],
  // save_due[67], zero fill to 72.
  output logic [71:0]  out_tdata
);
  import nto_pkg::*;

  cell_ctl_t ctl;
  entry_t    wr_entry;
  entry_t    cells [TABLE_ENTRIES];
  logic [71:0] res;

  nto_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_bits(in_tdata[99:0]),
    .out_tvalid, .out_tready, .out_bits(res),
    .head(cells[0]), .ctl, .wr_entry
  );

  // Cell 0 is the head; on a shift each cell takes its upper neighbor,
  // and the head wraps around to the last cell.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    nto_cell u_cell (
      .clk, .ctl, .is_head(g == 0), .wr_entry,
      .prev_entry(cells[(g + 1) % TABLE_ENTRIES]), .entry(cells[g])
    );
  end

  assign out_tdata = {4'd0, res[67:0]};
endmodule

// File: test/tb_neighbor_table_oldest_evict.sv
// Self-checking testbench of the neighbor table with oldest-entry eviction.
module tb_neighbor_table_oldest_evict;
  import nto_pkg::*;

  localparam int unsigned Entries = 16;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // func[0], key_hash[8:1], now_ms[40:9], advert_time[72:41], rssi[81:73],
  // snr[89:82], hop_count[97:90], node_kind[99:98], zero fill to 104.
  logic [103:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // found[0], slot[4:1], evicted[5], best_hops[13:6], used_entries[18:14],
  // clients_seen[34:19], repeaters_seen[50:35], rooms_seen[66:51],
  // save_due[67], zero fill to 72.
  logic [71:0]  out_tdata;

  // One advert or lookup request as the block sees it.
  typedef struct packed {
    logic        func;
    logic [7:0]  key;
    logic [31:0] now_ms;
    logic [31:0] adv_time;
    logic [8:0]  rssi;
    logic [7:0]  snr;
    logic [7:0]  hops;
    logic [1:0]  kind;
  } advert_t;

  // One table answer; the last member sits in the lowest bits, as in out_tdata.
  typedef struct packed {
    logic        save_due;
    logic [15:0] rooms;
    logic [15:0] repeaters;
    logic [15:0] clients;
    logic [4:0]  used;
    logic [7:0]  best_hops;
    logic        evicted;
    logic [3:0]  slot;
    logic        found;
  } answer_t;

  // Shadow copy of the table that predicts every answer.
  entry_t      shadow_tbl [Entries];
  int unsigned shadow_fill;
  logic [15:0] shadow_cnt [3];
  int unsigned shadow_inserts;

  answer_t     pending_answers [$];
  int unsigned error_count;
  int unsigned answers_seen;
  int unsigned evictions_seen;
  int unsigned saves_seen;

  // Idle control: in_idle_pct and out_idle_pct are percentages of cycles
  // in which the sender or receiver stalls; out_hold counts a long stall.
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int unsigned out_hold;
  logic [31:0] clock_ms;

  neighbor_table_oldest_evict #(.TABLE_ENTRIES(Entries)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Runs the table behavior on one accepted request and returns the answer.
  function automatic answer_t predict_answer(advert_t req);
    answer_t     ans;
    int unsigned idx;
    int unsigned pick;
    ans = '0;
    pick = 0;
    for (idx = 0; idx < shadow_fill; idx++) begin
      if (!ans.found && shadow_tbl[idx].key == req.key) begin
        ans.found = 1'b1;
        pick = idx;
      end
    end
    if (req.func == FuncLookup) begin
      if (ans.found) ans.best_hops = shadow_tbl[pick].hops;
    end else begin
      if (!ans.found) begin
        if (shadow_fill >= Entries) begin
          // Full table: replace the oldest entry, lowest slot on ties.
          pick = 0;
          for (idx = 1; idx < Entries; idx++)
            if (shadow_tbl[idx].seen_ms < shadow_tbl[pick].seen_ms) pick = idx;
          if (shadow_tbl[pick].kind != KindUnused &&
              shadow_cnt[shadow_tbl[pick].kind] != 16'd0)
            shadow_cnt[shadow_tbl[pick].kind]--;
          ans.evicted = 1'b1;
        end else begin
          pick = shadow_fill;
          shadow_fill++;
        end
        shadow_tbl[pick].key = req.key;
        shadow_tbl[pick].hops = req.hops;
        if (req.kind != KindUnused && shadow_cnt[req.kind] != CountMax)
          shadow_cnt[req.kind]++;
        shadow_inserts++;
        if (shadow_inserts >= SaveEvery) begin
          ans.save_due = 1'b1;
          shadow_inserts = 0;
        end
      end
      // A refresh overwrites the kind but keeps the counters as they are.
      shadow_tbl[pick].kind = req.kind;
      shadow_tbl[pick].seen_ms = req.now_ms;
      shadow_tbl[pick].adv_time = req.adv_time;
      shadow_tbl[pick].rssi = req.rssi;
      shadow_tbl[pick].snr = req.snr;
      if (req.hops < shadow_tbl[pick].hops) shadow_tbl[pick].hops = req.hops;
      ans.best_hops = shadow_tbl[pick].hops;
    end
    ans.slot = pick[3:0];
    ans.used = shadow_fill[4:0];
    ans.clients = shadow_cnt[0];
    ans.repeaters = shadow_cnt[1];
    ans.rooms = shadow_cnt[2];
    return ans;
  endfunction

  // Offers one request, waits for its transfer and queues the prediction.
  task automatic send_advert(advert_t req);
    do @(negedge clk); while (in_idle_pct != 0 && $urandom_range(99, 0) < in_idle_pct);
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, req.kind, req.hops, req.snr, req.rssi, req.adv_time, req.now_ms,
                 req.key, req.func};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_answers.push_back(predict_answer(req));
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Builds a request with random radio fields and the given key and action.
  function automatic advert_t make_advert(logic func, logic [7:0] key);
    advert_t req;
    req.func = func;
    req.key = key;
    clock_ms = clock_ms + $urandom_range(50, 1);
    req.now_ms = ($urandom_range(9, 0) == 0) ? $urandom() : clock_ms;
    req.adv_time = $urandom();
    req.rssi = 9'($urandom());
    req.snr = 8'($urandom());
    req.hops = 8'($urandom());
    req.kind = 2'($urandom_range(3, 0));
    return req;
  endfunction

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, plus a long counted hold when out_hold is set.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_hold != 0) begin
      out_hold <= out_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(out_idle_pct != 0 && $urandom_range(99, 0) < out_idle_pct);
    end
  end

  // Checks every answer transfer against the oldest prediction.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = answer_t'(out_tdata[67:0]);
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $display("%0t: answer with none expected, actual %h", $time, got);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (got.evicted) evictions_seen++;
        if (got.save_due) saves_seen++;
        if (got.found !== want.found || got.slot !== want.slot ||
            got.evicted !== want.evicted || got.best_hops !== want.best_hops ||
            got.used !== want.used || got.clients !== want.clients ||
            got.repeaters !== want.repeaters || got.rooms !== want.rooms ||
            got.save_due !== want.save_due) begin
          $display("%0t: answer mismatch, expected %h, actual %h", $time, want, got);
          error_count++;
        end
      end
    end
  end

  // Directed: empty lookups, fill to capacity, refreshes, eviction, field extremes.
  task automatic test_directed();
    advert_t req;
    int unsigned k;
    req = '0;
    req.func = FuncLookup;
    send_advert(req);                               // lookup miss on empty table
    req = '0;
    req.hops = 8'hFF;
    req.rssi = 9'h100;
    req.snr = 8'h80;
    send_advert(req);                               // insert key zero
    req.hops = 8'd3;
    req.kind = KindRoom;
    req.now_ms = 32'hFFFF_FFFF;
    req.adv_time = 32'hFFFF_FFFF;
    req.rssi = 9'h0FF;
    req.snr = 8'h7F;
    send_advert(req);                               // refresh, kind change, lower hops
    req.hops = 8'd9;
    send_advert(req);                               // refresh keeps the minimum
    req.func = FuncLookup;
    send_advert(req);                               // lookup hit
    for (k = 1; k < Entries; k++) begin
      req = '0;
      req.key = 8'(k * 17);
      req.now_ms = 32'(100 + k / 2);
      req.kind = 2'(k % 4);
      req.hops = 8'(k);
      send_advert(req);
    end
    req = '0;
    req.key = 8'hF0;
    req.kind = KindRepeater;
    req.now_ms = 32'd200;
    send_advert(req);                               // full table evicts oldest slot
    req.key = 8'hF1;
    send_advert(req);                               // tie on oldest time
    wait_drained();
  endtask

  // Random traffic mostly over a small key set so hits, refreshes and
  // evictions all happen often.
  task automatic test_random(int unsigned count);
    int unsigned k;
    logic [7:0]  key;
    for (k = 0; k < count; k++) begin
      key = ($urandom_range(3, 0) == 0) ? 8'($urandom()) : 8'($urandom_range(23, 0));
      send_advert(make_advert($urandom_range(3, 0) == 0, key));
    end
  endtask

  // The receiver stalls long while the sender keeps offering, then the
  // sender waits for everything to drain.
  task automatic test_backpressure();
    int unsigned k;
    out_hold = 400;
    for (k = 0; k < 12; k++) send_advert(make_advert(FuncUpdate, 8'($urandom_range(40, 0))));
    wait_drained();
  endtask

  initial begin
    int unsigned wait_cycles;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    out_hold = 0;
    clock_ms = 0;
    error_count = 0;
    answers_seen = 0;
    evictions_seen = 0;
    saves_seen = 0;
    shadow_fill = 0;
    shadow_inserts = 0;
    shadow_cnt[0] = '0;
    shadow_cnt[1] = '0;
    shadow_cnt[2] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(150);                               // long stretch without idling
    in_idle_pct = 33;
    out_idle_pct = 33;
    test_random(200);
    test_backpressure();
    test_random(220);

    wait_cycles = 0;
    while (pending_answers.size() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (80) @(negedge clk);
    $display("Covered %0d answers with %0d evictions and %0d save flags,",
             answers_seen, evictions_seen, saves_seen);
    $display("including lookups, refreshes, fills and long output stalls.");
    if (error_count == 0 && pending_answers.size() == 0) begin
      $display("tb_neighbor_table_oldest_evict: clean");
    end else begin
      $display("tb_neighbor_table_oldest_evict: errors");
    end
    $finish;
  end

  // Watchdog: about 600 items, with wide margin.
  initial begin
    #5000000;
    $display("tb_neighbor_table_oldest_evict: errors");
    $finish;
  end
endmodule
